// File: hw/rtl/bagr_pkg.sv
// Shared types and constants of the per-link BAG pacing regulator.
`default_nettype none

package bagr_pkg;

	// Field widths of the stream words and registers
	localparam int LINK_W   = 6;
	localparam int BAG_W    = 17;
	localparam int TAG_W    = 16;
	localparam int FACTOR_W = 17;
	localparam int LIMIT_W  = 4;

	// Stream word widths, padded to whole bytes
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 40;

	// Configuration port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// Register indexes, decoded from paddr[2]
	localparam logic REG_FACTOR = 1'b0;
	localparam logic REG_LIMIT  = 1'b1;

	// Register reset values: factor of 1.0 and the full queue
	localparam logic [FACTOR_W-1:0] FACTOR_ONE    = 17'h10000;
	localparam logic [LIMIT_W-1:0]  LIMIT_DEFAULT = 4'd8;

	// Kind of input word
	typedef enum logic [0:0] {
		CMD_ARRIVAL = 1'b0,
		CMD_EXPIRY  = 1'b1
	} cmd_t;

	// Result word, first member in the highest bits
	typedef struct packed {
		logic              queue_full_error;
		logic [BAG_W-1:0]  timer_delay_us;
		logic              timer_valid;
		logic [TAG_W-1:0]  release_tag;
		logic              release_valid;
	} result_t;

	localparam int RESULT_W = $bits(result_t);

endpackage

`default_nettype wire

// File: hw/rtl/bagr_link_table.sv
// Per-link state table: memory with registered read, entry valid bits and write forwarding.
`default_nettype none

module bagr_link_table #(
	parameter int NL = 64,
	parameter int LW = 6,
	parameter int SW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          rd_en,
	input  wire logic [LW-1:0] rd_idx,
	input  wire logic [LW-1:0] lk_idx,
	input  wire logic          wr_en,
	input  wire logic [LW-1:0] wr_idx,
	input  wire logic [SW-1:0] wr_data,
	output logic      [SW-1:0] cur_data
);

	logic [SW-1:0] mem [NL];
	logic [SW-1:0] rd_data_q;
	logic [NL-1:0] vld_q;
	logic          fwd_v_q;
	logic [LW-1:0] fwd_idx_q;
	logic [SW-1:0] fwd_data_q;

	// State memory, written by the word leaving the lookup stage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_idx];
		end
	end

	// An entry that was never written reads as the reset state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_idx] <= 1'b1;
		end
	end

	// The latest write, which the registered read may have missed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_v_q <= 1'b0;
		end else if (wr_en) begin
			fwd_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_idx_q  <= wr_idx;
			fwd_data_q <= wr_data;
		end
	end

	// Current state of the link in the lookup stage
	always_comb begin
		if (fwd_v_q && (fwd_idx_q == lk_idx)) begin
			cur_data = fwd_data_q;
		end else if (vld_q[lk_idx]) begin
			cur_data = rd_data_q;
		end else begin
			cur_data = '0;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/per_link_bag_pacing_regulator.sv
// Top level of the per-link BAG pacing regulator.
//
// The regulator takes one word per clock cycle unless the result side stalls, and gives
// one result word for each through the input, decision and result registers. Each word
// is a read-modify-write of its link's state (busy flag, queue head, queue count); the
// state table is read at acceptance and the previous word's write is forwarded, so words
// for the same link may follow back to back. A released frame's timer delay is its BAG
// times the reduction factor (unsigned Q16, saturated at one, truncated), from one 17 by
// 17 bit multiplier in the second stage. Waiting frames sit in one memory of QUEUE_DEPTH
// entries for each of at most 64 links. Reset takes effect at once: there is no clearing
// pass. Back-pressure on the result side stalls the whole pipeline.
`default_nettype none

module per_link_bag_pacing_regulator #(
	parameter int NUM_LINKS   = 64,
	parameter int QUEUE_DEPTH = 8
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Input stream
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// tdata: link_id[5:0], bag_us[22:6], frame_tag[38:23], zero pad[39]
	input  wire logic [bagr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// tuser: cmd[0]
	input  wire logic                                s_axis_tuser,
	// Result stream
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// tdata: release_valid[0], release_tag[16:1], timer_valid[17],
	// timer_delay_us[34:18], queue_full_error[35], zero pad[39:36]
	output logic [bagr_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
	// Configuration port
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [bagr_pkg::APB_ADDR_W-1:0]     paddr,
	input  wire logic [bagr_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [bagr_pkg::APB_DATA_W-1:0]          prdata,
	output logic                                     pready
);

	// Only 64 links can be named by the link id field
	localparam int NL   = (NUM_LINKS < 64) ? NUM_LINKS : 64;
	localparam int LW   = (NL > 1) ? $clog2(NL) : 1;
	localparam int HW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW   = $clog2(QUEUE_DEPTH + 1);
	localparam int SUMW = CW + 1;
	localparam int QN   = NL * QUEUE_DEPTH;
	localparam int QA   = (QN > 1) ? $clog2(QN) : 1;
	localparam int QDW  = bagr_pkg::BAG_W + bagr_pkg::TAG_W;
	localparam int PRODW = 2 * bagr_pkg::FACTOR_W;

	typedef struct packed {
		logic          busy;
		logic [HW-1:0] head;
		logic [CW-1:0] cnt;
	} lstate_t;

	// Configuration registers
	logic [bagr_pkg::FACTOR_W-1:0] factor_q;
	logic [bagr_pkg::LIMIT_W-1:0]  limit_q;
	logic                          cfg_wr;

	// Pipeline control
	logic adv;
	logic s1_v_q;
	logic s2_v_q;
	logic s3_v_q;

	// Stage 1: accepted word and link state
	bagr_pkg::cmd_t              cmd_s1;
	logic [bagr_pkg::LINK_W-1:0] link_s1;
	logic [bagr_pkg::BAG_W-1:0]  bag_s1;
	logic [bagr_pkg::TAG_W-1:0]  tag_s1;
	logic [LW-1:0]               lk_idx;
	logic [LW-1:0]               in_idx;
	lstate_t                     cur;
	lstate_t                     nxt;
	logic                        in_range;
	logic [7:0]                  lim8;
	logic                        full;
	logic [SUMW-1:0]             sum;
	logic [SUMW-1:0]             hinc;
	logic [HW-1:0]               slot;
	logic [HW-1:0]               head_nxt;
	logic [QA-1:0]               q_addr;
	logic                        st_wr;
	logic                        rel;
	logic                        tmr;
	logic                        err;
	logic                        push;
	logic                        pop;

	// Stage 2: decision and queue read data
	logic                       rel_s2;
	logic                       tmr_s2;
	logic                       err_s2;
	logic                       pop_s2;
	logic [bagr_pkg::BAG_W-1:0] bag_s2;
	logic [bagr_pkg::TAG_W-1:0] tag_s2;
	logic [QDW-1:0]             q_rd_s2;
	logic [QDW-1:0]             qmem [QN];
	logic [bagr_pkg::BAG_W-1:0] sel_bag;
	logic [bagr_pkg::TAG_W-1:0] sel_tag;
	logic [bagr_pkg::FACTOR_W-1:0] fac;
	logic [PRODW-1:0]           prod;
	bagr_pkg::result_t          res;

	// Stage 3: result register
	bagr_pkg::result_t res_s3;

	// Configuration writes and reads
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= bagr_pkg::FACTOR_ONE;
			limit_q  <= bagr_pkg::LIMIT_DEFAULT;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				bagr_pkg::REG_FACTOR: factor_q <= pwdata[bagr_pkg::FACTOR_W-1:0];
				bagr_pkg::REG_LIMIT:  limit_q  <= pwdata[bagr_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			bagr_pkg::REG_FACTOR: prdata = bagr_pkg::APB_DATA_W'(factor_q);
			bagr_pkg::REG_LIMIT:  prdata = bagr_pkg::APB_DATA_W'(limit_q);
			default:              prdata = '0;
		endcase
	end

	// The pipeline moves as a whole unless the result register is held
	assign adv           = !s3_v_q || m_axis_tready;
	assign s_axis_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			s2_v_q <= 1'b0;
			s3_v_q <= 1'b0;
		end else if (adv) begin
			s1_v_q <= s_axis_tvalid;
			s2_v_q <= s1_v_q;
			s3_v_q <= s2_v_q;
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1  <= bagr_pkg::cmd_t'(s_axis_tuser);
			link_s1 <= s_axis_tdata[5:0];
			bag_s1  <= s_axis_tdata[22:6];
			tag_s1  <= s_axis_tdata[38:23];
		end
	end

	assign in_idx   = LW'(s_axis_tdata[5:0]);
	assign lk_idx   = LW'(link_s1);
	assign in_range = 32'(link_s1) < NUM_LINKS;

	bagr_link_table #(
		.NL (NL),
		.LW (LW),
		.SW ($bits(lstate_t))
	) u_link_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (adv),
		.rd_idx   (in_idx),
		.lk_idx   (lk_idx),
		.wr_en    (st_wr && adv),
		.wr_idx   (lk_idx),
		.wr_data  (nxt),
		.cur_data (cur)
	);

	// Queue arithmetic: effective limit, tail slot and next head
	always_comb begin
		lim8 = (8'(limit_q) > 8'(QUEUE_DEPTH)) ? 8'(QUEUE_DEPTH) : 8'(limit_q);
		full = 8'(cur.cnt) >= lim8;
		sum  = SUMW'(cur.head) + SUMW'(cur.cnt);
		slot = (sum >= SUMW'(QUEUE_DEPTH)) ? HW'(sum - SUMW'(QUEUE_DEPTH)) : HW'(sum);
		hinc = SUMW'(cur.head) + SUMW'(1);
		head_nxt = (hinc == SUMW'(QUEUE_DEPTH)) ? '0 : HW'(hinc);
	end

	// Per-word decision and new link state
	always_comb begin
		nxt   = cur;
		st_wr = 1'b0;
		rel   = 1'b0;
		tmr   = 1'b0;
		err   = 1'b0;
		push  = 1'b0;
		pop   = 1'b0;
		if (s1_v_q && in_range) begin
			st_wr = 1'b1;
			case (cmd_s1)
				bagr_pkg::CMD_ARRIVAL: begin
					if (!cur.busy) begin
						rel      = 1'b1;
						tmr      = 1'b1;
						nxt.busy = 1'b1;
					end else if (full) begin
						err = 1'b1;
					end else begin
						push    = 1'b1;
						nxt.cnt = cur.cnt + CW'(1);
					end
				end
				default: begin
					if (cur.cnt == '0) begin
						nxt.busy = 1'b0;
					end else begin
						rel      = 1'b1;
						tmr      = 1'b1;
						pop      = 1'b1;
						nxt.head = head_nxt;
						nxt.cnt  = cur.cnt - CW'(1);
					end
				end
			endcase
		end
	end

	// Waiting frames: the tail slot on a push, the head on a pop
	assign q_addr = QA'(32'(lk_idx) * QUEUE_DEPTH + 32'(push ? slot : cur.head));

	always_ff @(posedge clk) begin
		if (push && adv) begin
			qmem[q_addr] <= {bag_s1, tag_s1};
		end
		if (adv) begin
			q_rd_s2 <= qmem[q_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rel_s2 <= rel;
			tmr_s2 <= tmr;
			err_s2 <= err;
			pop_s2 <= pop;
			bag_s2 <= bag_s1;
			tag_s2 <= tag_s1;
		end
	end

	// Timer delay: BAG times the saturated factor, truncated to whole microseconds
	always_comb begin
		sel_tag = pop_s2 ? q_rd_s2[bagr_pkg::TAG_W-1:0] : tag_s2;
		sel_bag = pop_s2 ? q_rd_s2[QDW-1:bagr_pkg::TAG_W] : bag_s2;
		fac     = (factor_q > bagr_pkg::FACTOR_ONE) ? bagr_pkg::FACTOR_ONE : factor_q;
		prod    = PRODW'(sel_bag) * PRODW'(fac);
		res.release_valid    = rel_s2;
		res.release_tag      = rel_s2 ? sel_tag : '0;
		res.timer_valid      = tmr_s2;
		res.timer_delay_us   = tmr_s2 ? prod[32:16] : '0;
		res.queue_full_error = err_s2;
	end

	// Result register
	always_ff @(posedge clk) begin
		if (adv) begin
			res_s3 <= res;
		end
	end

	assign m_axis_tvalid = s3_v_q;
	assign m_axis_tdata  = {(bagr_pkg::OUT_TDATA_W - bagr_pkg::RESULT_W)'(0), res_s3};

endmodule

`default_nettype wire

// File: hw/rtl/bagr_checker.sv
// Port-level checks of the pacing regulator and their binding to the top level.
`default_nettype none

module bagr_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            m_axis_tvalid,
	input wire logic                            m_axis_tready,
	input wire logic [bagr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input wire logic                            psel,
	input wire logic                            penable,
	input wire logic                            pwrite,
	input wire logic [bagr_pkg::APB_ADDR_W-1:0] paddr,
	input wire logic [bagr_pkg::APB_DATA_W-1:0] pwdata,
	input wire logic [bagr_pkg::APB_DATA_W-1:0] prdata,
	input wire logic                            pready
);

	bagr_pkg::result_t res;

	assign res = bagr_pkg::result_t'(m_axis_tdata[bagr_pkg::RESULT_W-1:0]);

	// A dropped frame gives nothing but the error flag
	a_drop_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && res.queue_full_error) |->
			(!res.release_valid && !res.timer_valid && res.release_tag == '0
			 && res.timer_delay_us == '0))
		else $error("dropped frame word carries a release or a timer");

	// Every release starts a timer, and no timer starts without a release
	a_rel_tmr: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (res.release_valid == res.timer_valid))
		else $error("release and timer request disagree");

	// Fields of an absent release or timer read as zero
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !res.timer_valid) |->
			(res.timer_delay_us == '0 && res.release_tag == '0))
		else $error("idle result word carries a tag or a delay");

	// A held result word stays as it is
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("result word changed while stalled");

	// The queue limit reads back as written
	a_limit_rb: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && paddr[2] == bagr_pkg::REG_LIMIT) |=>
			(paddr[2] != bagr_pkg::REG_LIMIT
			 || prdata == {28'd0, $past(pwdata[3:0])}))
		else $error("queue limit read-back mismatch");

endmodule

bind per_link_bag_pacing_regulator bagr_checker u_bagr_checker (.*);

`default_nettype wire

// File: tb/sv/per_link_bag_pacing_regulator_tb.sv
// Self-checking testbench for the per-link BAG pacing regulator, with a stream driver and monitor.
module per_link_bag_pacing_regulator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bagr_pkg::*;

	localparam int NUM_LINKS   = 64;
	localparam int QUEUE_DEPTH = 8;
	localparam int PHASES      = 6;

	// One input word as the testbench sees it
	typedef struct packed {
		cmd_t              cmd;
		logic [LINK_W-1:0] link;
		logic [BAG_W-1:0]  bag;
		logic [TAG_W-1:0]  tag;
	} link_word_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// tdata: link_id[5:0], bag_us[22:6], frame_tag[38:23], zero pad[39]
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	// tuser: cmd[0]
	logic                   s_axis_tuser = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// tdata: release_valid[0], release_tag[16:1], timer_valid[17],
	// timer_delay_us[34:18], queue_full_error[35], zero pad[39:36]
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [APB_ADDR_W-1:0]  paddr = '0;
	logic [APB_DATA_W-1:0]  pwdata = '0;
	logic [APB_DATA_W-1:0]  prdata;
	logic                   pready;

	per_link_bag_pacing_regulator #(
		.NUM_LINKS(NUM_LINKS),
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Shadow of the regulator's registers and per-link state
	logic [FACTOR_W-1:0] factor_reg = FACTOR_ONE;
	logic [LIMIT_W-1:0]  limit_reg = LIMIT_DEFAULT;
	logic                link_busy [NUM_LINKS];
	logic [2:0]          fifo_head [NUM_LINKS];
	logic [3:0]          fifo_count [NUM_LINKS];
	logic [TAG_W-1:0]    held_tag [NUM_LINKS*QUEUE_DEPTH];
	logic [BAG_W-1:0]    held_bag [NUM_LINKS*QUEUE_DEPTH];

	link_word_t pending_words [$];
	result_t    due_results [$];

	int words_queued = 0;
	int words_accepted = 0;
	int results_seen = 0;
	int frames_freed = 0;
	int frames_dropped = 0;
	int error_count = 0;
	int tx_gap = 0;
	int tx_calm = 0;
	int rx_stall = 0;
	int rx_calm = 0;

	initial begin
		for (int i = 0; i < NUM_LINKS; i++) begin
			link_busy[i] = 1'b0;
			fifo_head[i] = '0;
			fifo_count[i] = '0;
		end
	end

	// Clock and a single reset at the start
	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Run limit
	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// Gap length: mostly none, often short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(5, 30);
	endfunction

	// BAG scaled by the reduction factor, which saturates at one
	function automatic logic [BAG_W-1:0] paced_delay(logic [BAG_W-1:0] bag);
		logic [33:0]         prod;
		logic [FACTOR_W-1:0] f;
		f = (factor_reg > FACTOR_ONE) ? FACTOR_ONE : factor_reg;
		prod = 34'(bag) * 34'(f);
		return prod[32:16];
	endfunction

	// Apply one accepted word to the shadow state and give its result
	function automatic result_t regulate_word(link_word_t w);
		result_t     r;
		logic [3:0]  cap;
		logic [8:0]  slot;
		r = '0;
		if (w.cmd == CMD_ARRIVAL) begin
			if (!link_busy[w.link]) begin
				link_busy[w.link] = 1'b1;
				r.release_valid = 1'b1;
				r.release_tag = w.tag;
				r.timer_valid = 1'b1;
				r.timer_delay_us = paced_delay(w.bag);
				frames_freed++;
			end else begin
				cap = (limit_reg > QUEUE_DEPTH) ? 4'(QUEUE_DEPTH) : limit_reg;
				if (fifo_count[w.link] >= cap) begin
					r.queue_full_error = 1'b1;
					frames_dropped++;
				end else begin
					slot = {w.link, 3'(fifo_head[w.link] + fifo_count[w.link][2:0])};
					held_tag[slot] = w.tag;
					held_bag[slot] = w.bag;
					fifo_count[w.link] = fifo_count[w.link] + 4'd1;
				end
			end
		end else if (fifo_count[w.link] == 0) begin
			// An expiry with nothing waiting lets the link go idle.
			link_busy[w.link] = 1'b0;
		end else begin
			slot = {w.link, fifo_head[w.link]};
			r.release_valid = 1'b1;
			r.release_tag = held_tag[slot];
			r.timer_valid = 1'b1;
			r.timer_delay_us = paced_delay(held_bag[slot]);
			fifo_head[w.link] = fifo_head[w.link] + 3'd1;
			fifo_count[w.link] = fifo_count[w.link] - 4'd1;
			frames_freed++;
		end
		return r;
	endfunction

	// Input driver: predicts each accepted word, then offers the next after a random gap
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				due_results.push_back(regulate_word(link_word_t'({cmd_t'(s_axis_tuser),
					s_axis_tdata[5:0], s_axis_tdata[22:6], s_axis_tdata[38:23]})));
				words_accepted++;
			end
			if (tx_calm == 0 && $urandom_range(0, 99) == 0)
				tx_calm = $urandom_range(20, 80);
			else if (tx_calm > 0)
				tx_calm--;
			if (!s_axis_tvalid || s_axis_tready) begin
				if (tx_gap > 0) begin
					s_axis_tvalid <= 1'b0;
					tx_gap--;
				end else if (pending_words.size() != 0) begin
					link_word_t w;
					w = pending_words.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {1'b0, w.tag, w.bag, w.link};
					s_axis_tuser <= w.cmd;
					tx_gap = (tx_calm > 0) ? 0 : pick_gap();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result side back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (rx_calm == 0 && $urandom_range(0, 99) == 0)
				rx_calm = $urandom_range(20, 80);
			else if (rx_calm > 0)
				rx_calm--;
			if (rx_stall > 0) begin
				m_axis_tready <= 1'b0;
				rx_stall--;
			end else begin
				m_axis_tready <= 1'b1;
				rx_stall = (rx_calm > 0) ? 0 : pick_gap();
			end
		end
	end

	task automatic check_field(string name, logic [16:0] want, logic [16:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			error_count++;
		end
	endtask

	// Monitor: compare each result word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (due_results.size() == 0) begin
				$display("%0t: result with none expected, actual %h", $time, m_axis_tdata);
				error_count++;
			end else begin
				result_t want;
				result_t got;
				want = due_results.pop_front();
				got = result_t'(m_axis_tdata[RESULT_W-1:0]);
				check_field("release_valid", want.release_valid, got.release_valid);
				check_field("release_tag", want.release_tag, got.release_tag);
				check_field("timer_valid", want.timer_valid, got.timer_valid);
				check_field("timer_delay_us", want.timer_delay_us, got.timer_delay_us);
				check_field("queue_full_error", want.queue_full_error, got.queue_full_error);
				check_field("pad", '0, m_axis_tdata[OUT_TDATA_W-1:RESULT_W]);
			end
		end
	end

	task automatic queue_word(cmd_t cmd, int link, int bag, int tag);
		pending_words.push_back({cmd, LINK_W'(link), BAG_W'(bag), TAG_W'(tag)});
		words_queued++;
	endtask

	// Random words, mostly on a few busy links so that queues fill and drain
	task automatic queue_random(int n);
		int r;
		int link;
		int bag;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				link = $urandom_range(0, 7);
			else if (r < 80)
				link = $urandom_range(0, 1) ? NUM_LINKS - 1 : 0;
			else
				link = $urandom_range(0, NUM_LINKS - 1);
			r = $urandom_range(0, 99);
			if (r < 5)
				bag = 0;
			else if (r < 10)
				bag = 17'h1FFFF;
			else if (r < 30)
				bag = $urandom & 17'h1FFFF;
			else
				bag = $urandom_range(1, 128000);
			queue_word(($urandom_range(0, 99) < 55) ? CMD_ARRIVAL : CMD_EXPIRY, link, bag,
				$urandom & 16'hFFFF);
		end
	endtask

	// Wait until every word is in and every result out, then let the pipeline settle
	task automatic drain();
		while (pending_words.size() != 0 || words_accepted != words_queued ||
				due_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_register(logic index, logic [APB_DATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (index == REG_FACTOR)
			factor_reg = value[FACTOR_W-1:0];
		else
			limit_reg = value[LIMIT_W-1:0];
	endtask

	// Stimulus and end of run
	initial begin
		logic [FACTOR_W-1:0] factors [PHASES];
		logic [LIMIT_W-1:0]  limits [PHASES];
		factors = '{17'd0, 17'h1FFFF, 17'd1, 17'd32768, 17'd0, FACTOR_ONE};
		limits = '{4'd0, 4'd15, 4'd1, 4'd3, 4'd0, LIMIT_DEFAULT};
		factors[4] = $urandom_range(1, 65535);
		limits[4] = $urandom_range(1, 8);
		wait (arst_n === 1'b1);

		// Directed words at reset settings: field extremes, queueing, wrap, drop, idle expiry
		queue_word(CMD_ARRIVAL, 0, 128000, 16'hFFFF);
		queue_word(CMD_ARRIVAL, 0, 17'h1FFFF, 16'h0000);
		queue_word(CMD_ARRIVAL, 0, 1, 16'h1234);
		queue_word(CMD_ARRIVAL, 63, 0, 16'hAAAA);
		queue_word(CMD_EXPIRY, 0, 0, 0);
		queue_word(CMD_EXPIRY, 0, 17'h1FFFF, 16'hFFFF);
		queue_word(CMD_EXPIRY, 0, 0, 0);
		queue_word(CMD_EXPIRY, 0, 0, 0);
		queue_word(CMD_ARRIVAL, 42, 17'h0AAAA, 16'h5555);
		for (int i = 0; i < 9; i++)
			queue_word(CMD_ARRIVAL, 42, (i % 2) ? 17'h15555 : 17'h0AAAA, 16'h5550 + i);
		queue_word(CMD_EXPIRY, 42, 0, 0);
		queue_word(CMD_ARRIVAL, 42, 3, 16'h0F0F);
		queue_word(CMD_EXPIRY, 21, 0, 0);
		queue_word(CMD_EXPIRY, 63, 0, 0);
		queue_random(150);
		drain();

		// Register settings, extremes and saturating values among them
		for (int p = 0; p < PHASES; p++) begin
			write_register(REG_FACTOR, 32'(factors[p]));
			write_register(REG_LIMIT, 32'(limits[p]));
			queue_random(125);
			drain();
		end

		$display("Ran %0d words over %0d register settings: %0d results, %0d frames freed, %0d dropped.",
			words_accepted, PHASES + 1, results_seen, frames_freed, frames_dropped);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/bagr_pkg.sv
hw/rtl/bagr_link_table.sv
hw/rtl/per_link_bag_pacing_regulator.sv
hw/rtl/bagr_checker.sv
tb/sv/per_link_bag_pacing_regulator_tb.sv
